/* hw/rtl/fresnel_dielectric_reflectance_core_assert.svh */
// assertion macros for the fresnel reflectance core
// used by the port checker; no other dependencies
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_CORE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_CORE_ASSERT_SVH

// implication checked on every rising edge outside reset
`define FDR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define FDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/fdr_pkg.sv */
// shared constants and types for the fresnel reflectance core
// no dependencies
`default_nettype none
package fdr_pkg;
   localparam int ONE_Q14 = 16384;
   localparam int ONE_Q12 = 4096;
   localparam int COS_W = 16;
   localparam int REFL_W = 15;
   localparam int NIDX_W = 16;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTIVE_INDEX = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_SELECT = 1'd1;
   // radicand width and cell counts
   localparam int RAD_W = 62;
   localparam int SQRT_W = 31;
   localparam int DIV_Q_W = 15;
   // shared payload of the pipeline
   typedef struct packed {
      logic        vld;
      logic        tir;
      logic        mode;
      logic [63:0] a;
      logic [63:0] b;
      logic [15:0] c;
      logic [15:0] ni;
      logic [15:0] n;
   } stage_type;
endpackage
`default_nettype wire

/* hw/rtl/fdr_sqrt_cell.sv */
// one cell of the restoring square root chain, one result bit per cell
// depends on fdr_pkg
`default_nettype none
module fdr_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        vld_in_i,
   input  wire logic [63:0] rem_i,
   input  wire logic [63:0] root_i,
   input  wire logic [63:0] aux_i,
   output logic             vld_o,
   output logic [63:0]      rem_o,
   output logic [63:0]      root_o,
   output logic [63:0]      aux_o
);
   import fdr_pkg::*;
   localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_W - 1 - STEP));
   logic [63:0] trial;
   logic [63:0] rem_ff, root_ff, aux_ff;
   logic        vld_ff;
   logic [63:0] rem_in, root_in;

   // compare and subtract one bit pair
   always_comb begin
      trial = root_i + BIT;
      if (rem_i >= trial) begin
         rem_in = rem_i - trial;
         root_in = (root_i >> 1) + BIT;
      end else begin
         rem_in = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in_i;
      rem_ff <= rem_in;
      root_ff <= root_in;
      aux_ff <= aux_i;
   end
   assign vld_o = vld_ff;
   assign rem_o = rem_ff;
   assign root_o = root_ff;
   assign aux_o = aux_ff;
endmodule
`default_nettype wire

/* hw/rtl/fdr_div_cell.sv */
// one cell of a restoring divider chain, one quotient bit per cell, two lanes
// depends on fdr_pkg
`default_nettype none
module fdr_div_cell #(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic [63:0] num_i [2],
   input  wire logic [63:0] den_i [2],
   input  wire logic [15:0] quo_i [2],
   output logic [63:0]      num_o [2],
   output logic [63:0]      den_o [2],
   output logic [15:0]      quo_o [2]
);
   import fdr_pkg::*;
   localparam int SH = DIV_Q_W - 1 - STEP;
   logic [63:0] num_ff [2], den_ff [2];
   logic [15:0] quo_ff [2];
   logic [63:0] num_in [2];
   logic [15:0] quo_in [2];
   logic [79:0] dsh [2];

   // trial subtract of the shifted divisor in each lane
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         dsh[l] = {16'd0, den_i[l]} << SH;
         if ({16'd0, num_i[l]} >= dsh[l]) begin
            num_in[l] = num_i[l] - dsh[l][63:0];
            quo_in[l] = quo_i[l] | (16'd1 << SH);
         end else begin
            num_in[l] = num_i[l];
            quo_in[l] = quo_i[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_i;
      quo_ff <= quo_in;
   end
   assign num_o = num_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;
endmodule
`default_nettype wire

/* hw/rtl/fresnel_dielectric_reflectance_core.sv */
// top level of the fresnel reflectance core: front end, sqrt and divider cell chains
// depends on fdr_pkg, fdr_sqrt_cell, fdr_div_cell
`default_nettype none
// One item enters per clock (busy is always low) and its result appears on the
// result ports as a one-cycle rsp_valid pulse, in order; the receiver cannot
// stall. Each item passes input stages, a 31-cell square root chain, multiply
// stages, a 15-cell divider chain and an output stage. Schlick and total
// reflection items ride the same chain so ordering always holds. Configuration
// writes take effect for items accepted afterwards.
module fresnel_dielectric_reflectance_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic signed [fdr_pkg::COS_W-1:0] req_cos_incidence,
   output logic                                rsp_valid,
   output logic [fdr_pkg::REFL_W-1:0]          rsp_reflectance,
   output logic                                rsp_total_reflection,
   input  wire logic                           csr_write_enable,
   input  wire logic [fdr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fdr_pkg::CSR_W-1:0]      csr_write_data
);
   import fdr_pkg::*;

   logic [15:0] index_ff;
   logic        mode_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 16'd6144;
         mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REFRACTIVE_INDEX: index_ff <= csr_write_data;
            CSR_MODEL_SELECT:     mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end
   assign busy = 1'b0;

   // stage 0: fold cosine, clamp index
   logic        s0_vld_ff, s0_ent_ff, s0_mode_ff;
   logic [15:0] s0_c_ff, s0_n_ff;
   logic [15:0] raw, c_in, n_in;
   logic        ent;
   always_comb begin
      raw = req_cos_incidence;
      ent = raw[15];
      c_in = ent ? (16'd0 - raw) : raw;
      if (ent && raw == 16'h8000) c_in = 16'd16384;
      if (c_in > 16'd16384) c_in = 16'd16384;
      n_in = (index_ff < 16'd4096) ? 16'd4096 : index_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) s0_vld_ff <= 1'b0;
      else s0_vld_ff <= start;
      s0_ent_ff <= ent;
      s0_mode_ff <= mode_ff;
      s0_c_ff <= c_in;
      s0_n_ff <= n_in;
   end

   // stage 1: squares
   logic        s1_vld_ff, s1_mode_ff;
   logic [15:0] s1_c_ff, s1_ni_ff, s1_nt_ff, s1_n_ff;
   logic [31:0] s1_nt2_ff, s1_ni2_ff, s1_c2_ff;
   logic [15:0] ni0, nt0;
   assign ni0 = s0_ent_ff ? 16'd4096 : s0_n_ff;
   assign nt0 = s0_ent_ff ? s0_n_ff : 16'd4096;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else s1_vld_ff <= s0_vld_ff;
      s1_mode_ff <= s0_mode_ff;
      s1_c_ff <= s0_c_ff;
      s1_ni_ff <= ni0;
      s1_nt_ff <= nt0;
      s1_n_ff <= s0_n_ff;
      s1_nt2_ff <= nt0 * nt0;
      s1_ni2_ff <= ni0 * ni0;
      s1_c2_ff <= s0_c_ff * s0_c_ff;
   end

   // stage 2: t2 = ni^2 * (2^28 - c^2), one 32x29 product
   logic        s2_vld_ff, s2_mode_ff;
   logic [15:0] s2_c_ff, s2_ni_ff, s2_nt_ff, s2_n_ff;
   logic [31:0] s2_nt2_ff;
   logic [63:0] s2_t2_ff;
   logic [28:0] omc;
   assign omc = 29'h1000_0000 - {1'b0, s1_c2_ff[27:0]} - {s1_c2_ff[28], 28'd0};
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else s2_vld_ff <= s1_vld_ff;
      s2_mode_ff <= s1_mode_ff;
      s2_c_ff <= s1_c_ff;
      s2_ni_ff <= s1_ni_ff;
      s2_nt_ff <= s1_nt_ff;
      s2_n_ff <= s1_n_ff;
      s2_nt2_ff <= s1_nt2_ff;
      s2_t2_ff <= {32'd0, s1_ni2_ff} * {35'd0, omc};
   end

   // stage 3: radicand and total reflection test
   stage_type s3_ff;
   logic [63:0] t1;
   assign t1 = {4'd0, s2_nt2_ff, 28'd0};
   always_ff @(posedge clock) begin
      if (reset) s3_ff.vld <= 1'b0;
      else s3_ff.vld <= s2_vld_ff;
      s3_ff.tir <= (t1 <= s2_t2_ff);
      s3_ff.mode <= s2_mode_ff;
      s3_ff.a <= t1 - s2_t2_ff;
      s3_ff.b <= {48'd0, s2_nt_ff};
      s3_ff.c <= s2_c_ff;
      s3_ff.ni <= s2_ni_ff;
      s3_ff.n <= s2_n_ff;
   end

   // square root chain: rem in a, nt in aux low bits, packed sideband in aux
   logic [63:0] sq_rem [SQRT_W+1], sq_root [SQRT_W+1], sq_aux [SQRT_W+1];
   logic        sq_vld [SQRT_W+1];
   assign sq_vld[0] = s3_ff.vld;
   assign sq_rem[0] = s3_ff.a;
   assign sq_root[0] = 64'd0;
   assign sq_aux[0] = {13'd0, s3_ff.tir, s3_ff.mode, 1'b0, s3_ff.c,
                       s3_ff.ni, s3_ff.b[15:0]};
   logic [15:0] n_pipe [SQRT_W+1];
   assign n_pipe[0] = s3_ff.n;
   for (genvar g = 0; g < SQRT_W; g++) begin : g_sqrt
      fdr_sqrt_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .vld_in_i(sq_vld[g]), .rem_i(sq_rem[g]),
         .root_i(sq_root[g]), .aux_i(sq_aux[g]), .vld_o(sq_vld[g+1]),
         .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1]), .aux_o(sq_aux[g+1]));
      always_ff @(posedge clock) n_pipe[g+1] <= n_pipe[g];
   end
   logic sq_v;
   logic [15:0] q_nt, q_ni, q_c, q_n;
   logic q_tir, q_mode;
   logic [63:0] q_t;
   always_comb begin
      sq_v = sq_vld[SQRT_W] & ~reset;
      q_nt = sq_aux[SQRT_W][15:0];
      q_ni = sq_aux[SQRT_W][31:16];
      q_c = sq_aux[SQRT_W][47:32];
      q_mode = sq_aux[SQRT_W][49];
      q_tir = sq_aux[SQRT_W][50];
      q_t = sq_root[SQRT_W];
      q_n = n_pipe[SQRT_W];
   end

   // stage m1: fresnel products (ni*c, nt^2, ni*T) and schlick first terms
   logic        m1_vld_ff, m1_tir_ff, m1_mode_ff;
   logic [31:0] m1_a_ff, m1_nt2_ff;
   logic [47:0] m1_q_ff;
   logic [31:0] m1_tt_ff;
   logic [15:0] m1_c_ff;
   logic [31:0] m1_d2_ff;
   logic [32:0] m1_s2_ff;
   logic [15:0] dn;
   logic [16:0] sn;
   assign dn = q_n - 16'd4096;
   assign sn = {1'b0, q_n} + 17'd4096;
   always_ff @(posedge clock) begin
      if (reset) m1_vld_ff <= 1'b0;
      else m1_vld_ff <= sq_v;
      m1_tir_ff <= q_tir;
      m1_mode_ff <= q_mode;
      m1_a_ff <= q_ni * q_c;
      m1_nt2_ff <= q_nt * q_nt;
      m1_q_ff <= {16'd0, q_t[31:0]} * {32'd0, q_ni};
      m1_tt_ff <= q_t[31:0];
      m1_c_ff <= q_c;
      m1_d2_ff <= dn * dn;
      m1_s2_ff <= {16'd0, sn} * {16'd0, sn};
   end

   // stage m2: p = nt^2*c, sums and differences, schlick m
   logic        m2_vld_ff, m2_tir_ff, m2_mode_ff;
   logic [63:0] m2_na_ff [2], m2_da_ff [2];
   logic [15:0] m2_m_ff;
   logic [63:0] p;
   logic [63:0] av, bv, qv;
   logic [15:0] mm;
   always_comb begin
      p = {32'd0, m1_nt2_ff} * {48'd0, m1_c_ff};
      av = {32'd0, m1_a_ff};
      bv = {32'd0, m1_tt_ff};
      qv = {16'd0, m1_q_ff};
      mm = 16'd16384 - m1_c_ff;
   end
   // lane 0 is rs, lane 1 is rp in fresnel mode; lane 0 is r0 in schlick mode
   always_ff @(posedge clock) begin
      if (reset) m2_vld_ff <= 1'b0;
      else m2_vld_ff <= m1_vld_ff;
      m2_tir_ff <= m1_tir_ff;
      m2_mode_ff <= m1_mode_ff;
      m2_m_ff <= mm;
      if (m1_mode_ff) begin
         m2_da_ff[0] <= {31'd0, m1_s2_ff};
         m2_na_ff[0] <= ({32'd0, m1_d2_ff} << 14) + {32'd0, m1_s2_ff[32:1]};
         m2_da_ff[1] <= 64'd1;
         m2_na_ff[1] <= 64'd0;
      end else begin
         m2_da_ff[0] <= av + bv;
         m2_na_ff[0] <= (((av >= bv) ? av - bv : bv - av) << 14) + ((av + bv) >> 1);
         m2_da_ff[1] <= p + qv;
         m2_na_ff[1] <= (((p >= qv) ? p - qv : qv - p) << 14) + ((p + qv) >> 1);
      end
   end

   // divider chain, schlick power terms ride along
   logic [63:0] dv_num [DIV_Q_W+1][2], dv_den [DIV_Q_W+1][2];
   logic [15:0] dv_quo [DIV_Q_W+1][2];
   logic        dv_vld [DIV_Q_W+1], dv_tir [DIV_Q_W+1], dv_mode [DIV_Q_W+1];
   logic [15:0] dv_m [DIV_Q_W+1];
   logic [31:0] dv_pw [DIV_Q_W+1];
   assign dv_num[0] = m2_na_ff;
   assign dv_den[0] = m2_da_ff;
   assign dv_quo[0][0] = 16'd0;
   assign dv_quo[0][1] = 16'd0;
   assign dv_vld[0] = m2_vld_ff;
   assign dv_tir[0] = m2_tir_ff;
   assign dv_mode[0] = m2_mode_ff;
   assign dv_m[0] = m2_m_ff;
   assign dv_pw[0] = {16'd0, m2_m_ff};
   for (genvar g = 0; g < DIV_Q_W; g++) begin : g_div
      fdr_div_cell #(.STEP(g)) u_cell (
         .clock(clock), .num_i(dv_num[g]), .den_i(dv_den[g]), .quo_i(dv_quo[g]),
         .num_o(dv_num[g+1]), .den_o(dv_den[g+1]), .quo_o(dv_quo[g+1]));
      // power steps run in the first four cells: pw = rnd(pw*m/2^14)
      logic [31:0] pw_in;
      logic [47:0] prod;
      always_comb begin
         prod = {16'd0, dv_pw[g]} * {32'd0, dv_m[g]};
         pw_in = (g < 4) ? 32'((prod + 48'd8192) >> 14) : dv_pw[g];
      end
      always_ff @(posedge clock) begin
         if (reset) dv_vld[g+1] <= 1'b0;
         else dv_vld[g+1] <= dv_vld[g];
         dv_tir[g+1] <= dv_tir[g];
         dv_mode[g+1] <= dv_mode[g];
         dv_m[g+1] <= dv_m[g];
         dv_pw[g+1] <= pw_in;
      end
   end

   // final stage: combine
   logic        o_vld_ff, o_tir_ff, o_mode_ff;
   logic [31:0] o_x_ff;
   logic [15:0] o_r0_ff;
   logic [15:0] rs, rp, r0;
   logic [31:0] sq_sum;
   always_comb begin
      rs = dv_quo[DIV_Q_W][0];
      rp = dv_quo[DIV_Q_W][1];
      r0 = (rs > 16'd16384) ? 16'd16384 : rs;
      sq_sum = ({16'd0, rs} * {16'd0, rs}) + ({16'd0, rp} * {16'd0, rp});
   end
   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else o_vld_ff <= dv_vld[DIV_Q_W];
      o_tir_ff <= dv_tir[DIV_Q_W];
      o_mode_ff <= dv_mode[DIV_Q_W];
      o_r0_ff <= r0;
      if (dv_mode[DIV_Q_W])
         o_x_ff <= 32'(({16'd0, 16'd16384 - r0} * {16'd0, dv_pw[DIV_Q_W][15:0]}) + 32'd8192)
                   >> 14;
      else
         o_x_ff <= 32'((33'(sq_sum) + 33'd16384) >> 15);
   end

   logic [31:0] refl;
   always_comb begin
      refl = o_mode_ff ? o_x_ff + {16'd0, o_r0_ff} : o_x_ff;
      if (refl > 32'd16384) refl = 32'd16384;
      if (o_tir_ff) refl = 32'd16384;
   end
   assign rsp_valid = o_vld_ff;
   assign rsp_reflectance = refl[14:0];
   assign rsp_total_reflection = o_tir_ff;
endmodule
`default_nettype wire

/* hw/rtl/fdr_checker.sv */
// port checker for the fresnel reflectance core, bound to the top level
// depends on fresnel_dielectric_reflectance_core_assert.svh
`default_nettype none
`include "fresnel_dielectric_reflectance_core_assert.svh"
module fdr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [14:0] rsp_reflectance,
   input wire logic        rsp_total_reflection
);
   // reflectance never exceeds one
   `FDR_ASSERT_IMP(a_range, clock, reset, rsp_valid, rsp_reflectance <= 15'd16384, "refl > 1")
   // total reflection always reports full reflectance
   `FDR_ASSERT_IMP(a_tir, clock, reset, rsp_valid && rsp_total_reflection, rsp_reflectance == 15'd16384, "tir value")
   // the core never stalls
   `FDR_ASSERT_IMP(a_busy, clock, reset, 1'b1, !busy, "busy raised")
   // no result right after reset
   `FDR_ASSERT_NEXT(a_rst, clock, 1'b0, reset, !rsp_valid, "result after reset")
endmodule
bind fresnel_dielectric_reflectance_core fdr_checker u_fdr_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_reflectance(rsp_reflectance), .rsp_total_reflection(rsp_total_reflection));
`default_nettype wire
